// File: design/swlrl_pkg.sv
// Shared types and constants for the sliding-window log rate limiter.
// Holds the controller/datapath command and status structs and field widths.
// No dependencies; every other file of the block imports this package.
package swlrl_pkg;

    // Fixed field widths of the item and register interfaces.
    localparam int FLOW_FIELD_W = 6;
    localparam int NOW_W        = 32;
    localparam int LIMIT_W      = 5;
    localparam int WINDOW_W     = 32;
    localparam int COUNT_OUT_W  = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd10;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60;

    // Register indexes, taken from address bit 2.
    typedef enum logic [0:0] {
        REG_LIMIT  = 1'b0,
        REG_WINDOW = 1'b1
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // accept an input item this cycle
        logic fetch;   // load head and count of the flow
        logic pop;     // drop the oldest stamp of the flow
        logic commit;  // decide, write back and load the result
        logic clear;   // clear one ring-state entry after reset
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_bad;      // incoming flow index is out of range
        logic clear_last;  // clearing pass is at its last entry
        logic count_zero;  // no stamps left for the flow
        logic stale;       // oldest stamp is older than the window
        logic out_free;    // result register can take a new item
    } t_sts;

endpackage

// File: design/sliding_window_log_rate_limiter_core.sv
// Per-flow sliding-window log rate limiter: each accepted request goes through
// the fetch, trim and decide steps, and the next request is taken only after
// the result of the last one has been loaded into the output register. The
// trim step drops the stale stamps of the flow, 0 to LOG_DEPTH of them; the
// trim loop reads one stamp per cycle from the single read port of the stamp
// memory. A request for a flow index at or above FLOW_SLOTS skips the fetch
// and trim steps and is rejected with a zero count. A result still waiting in
// the output register holds the next item in its decide step until the result
// has been taken. After reset the per-flow head and count memory is cleared,
// one flow per cycle; no item is accepted until then, while register writes
// are taken at any time. A result waiting in the output register stalls only
// the next result, not the trimming of the following item. Registers:
// request_limit at 0x0 and window_length at 0x4.
//
// Top level of the rate limiter: register port and stream packing.
// Instantiates swlrl_ctrl and swlrl_dp; depends on swlrl_pkg.
module sliding_window_log_rate_limiter_core #(
    parameter int FLOW_SLOTS = 64,
    parameter int LOG_DEPTH  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Bits [5:0] flow_index, [37:6] now_ticks, [39:38] zero.
    input  logic [swlrl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Bit [0] allowed, [5:1] window_count, [7:6] zero.
    output logic [swlrl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swlrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swlrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swlrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import swlrl_pkg::*;

    logic [LIMIT_W-1:0]     r_limit;
    logic [WINDOW_W-1:0]    r_window;
    t_reg_idx               reg_idx;
    logic                   cfg_write;
    t_cmd                   cmd;
    t_sts                   sts;
    logic                   out_allowed;
    logic [COUNT_OUT_W-1:0] out_count;

    // Register decode; the index comes from address bit 2.
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_window <= WINDOW_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                REG_WINDOW: r_window <= pwdata[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_LIMIT:  prdata = APB_DATA_W'(r_limit);
            REG_WINDOW: prdata = APB_DATA_W'(r_window);
            default:    prdata = '0;
        endcase
    end

    swlrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swlrl_dp #(
        .FLOW_SLOTS (FLOW_SLOTS),
        .LOG_DEPTH  (LOG_DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_flow_index   (s_axis_tdata[FLOW_FIELD_W-1:0]),
        .i_now_ticks    (s_axis_tdata[FLOW_FIELD_W+NOW_W-1:FLOW_FIELD_W]),
        .i_limit        (r_limit),
        .i_window       (r_window),
        .i_m_tready     (m_axis_tready),
        .o_m_tvalid     (m_axis_tvalid),
        .o_allowed      (out_allowed),
        .o_window_count (out_count)
    );

    // Result packing, allowed in the lowest bit.
    assign m_axis_tdata = {{(OUT_TDATA_W - COUNT_OUT_W - 1){1'b0}}, out_count, out_allowed};

endmodule

// File: design/swlrl_ctrl.sv
// Controller state machine of the rate limiter.
// Sequences clearing, fetch, trim and decide; drives the datapath by t_cmd.
// Depends on swlrl_pkg.
module swlrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  swlrl_pkg::t_sts   i_sts,
    output swlrl_pkg::t_cmd   o_cmd
);
    import swlrl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_TRIM,
        S_DECIDE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    // Commands follow from the current state and the datapath status.
    always_comb begin
        o_cmd        = '0;
        o_cmd.take   = r_ready & i_s_tvalid;
        o_cmd.fetch  = (r_state == S_FETCH);
        o_cmd.pop    = (r_state == S_TRIM) & ~i_sts.count_zero & i_sts.stale;
        o_cmd.commit = (r_state == S_DECIDE) & i_sts.out_free;
        o_cmd.clear  = (r_state == S_CLEAR);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd.take) begin
                    n_state = i_sts.in_bad ? S_DECIDE : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_TRIM;
            end
            S_TRIM: begin
                if (!o_cmd.pop) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

    // One item at a time: after an accept the input side closes.
    a_take_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> !o_s_tready)
        else $error("input still ready after an item was accepted");

    // A committed item reopens the input side in the next cycle.
    a_commit_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE) && o_s_tready)
        else $error("input not reopened after commit");

    // No item is taken or finished while the ring state is being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready && !o_cmd.commit)
        else $error("activity during the clearing pass");

endmodule

// File: design/swlrl_dp.sv
// Datapath of the rate limiter: ring-state memory, stamp memory, trim
// compare, limit decision and result register. Driven by swlrl_ctrl.
// Depends on swlrl_pkg.
module swlrl_dp #(
    parameter int FLOW_SLOTS = 64,
    parameter int LOG_DEPTH  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swlrl_pkg::t_cmd                     i_cmd,
    output swlrl_pkg::t_sts                     o_sts,
    input  logic [swlrl_pkg::FLOW_FIELD_W-1:0]  i_flow_index,
    input  logic [swlrl_pkg::NOW_W-1:0]         i_now_ticks,
    input  logic [swlrl_pkg::LIMIT_W-1:0]       i_limit,
    input  logic [swlrl_pkg::WINDOW_W-1:0]      i_window,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic                                o_allowed,
    output logic [swlrl_pkg::COUNT_OUT_W-1:0]   o_window_count
);
    import swlrl_pkg::*;

    localparam int FW   = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int HW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW   = $clog2(LOG_DEPTH + 1);
    localparam int AW   = (FLOW_SLOTS * LOG_DEPTH > 1) ?
                          $clog2(FLOW_SLOTS * LOG_DEPTH) : 1;
    localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int CMPW = (STAMP_BITS > WINDOW_W) ? STAMP_BITS : WINDOW_W;
    localparam int SUMW = CW + 1;
    localparam int RSW  = HW + CW;

    // Memories: per-flow {head, count} and the stamp log of all flows.
    logic [RSW-1:0]        ring_mem  [FLOW_SLOTS];
    logic [STAMP_BITS-1:0] stamp_mem [FLOW_SLOTS * LOG_DEPTH];

    logic [RSW-1:0]        r_ring_rd;
    logic [STAMP_BITS-1:0] r_stamp_rd;

    // Item context and working ring pointers.
    logic [FW-1:0]         r_flow;
    logic [STAMP_BITS-1:0] r_now;
    logic                  r_bad;
    logic [HW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [FW-1:0]         r_clr_idx;

    // Result register.
    logic                   r_out_valid;
    logic                   r_allowed;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic                  in_bad;
    logic [FW-1:0]         in_idx;
    logic [FW-1:0]         ring_raddr;
    logic [FW-1:0]         ring_waddr;
    logic [RSW-1:0]        ring_wdata;
    logic                  ring_we;
    logic [HW-1:0]         rd_head;
    logic [CW-1:0]         rd_count;
    logic [HW-1:0]         head_inc;
    logic [HW-1:0]         head_sel;
    logic [AW-1:0]         flow_base;
    logic [AW-1:0]         stamp_raddr;
    logic [AW-1:0]         stamp_waddr;
    logic                  stamp_we;
    logic [SUMW-1:0]       tail_sum;
    logic [HW-1:0]         tail;
    logic [STAMP_BITS-1:0] age;
    logic [LW-1:0]         limit_sat;
    logic                  accept_req;
    logic [CW-1:0]         count_new;
    logic                  out_free;

    // Input flow check and memory index.
    assign in_bad = (32'(i_flow_index) >= 32'(FLOW_SLOTS));
    assign in_idx = in_bad ? '0 : FW'(i_flow_index);

    assign rd_head  = r_ring_rd[RSW-1:CW];
    assign rd_count = r_ring_rd[CW-1:0];

    // Ring pointer arithmetic modulo the log depth.
    assign head_inc = (32'(r_head) == 32'(LOG_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum = SUMW'(r_head) + SUMW'(r_count);
    assign tail     = (tail_sum >= SUMW'(LOG_DEPTH)) ?
                      HW'(tail_sum - SUMW'(LOG_DEPTH)) : HW'(tail_sum);

    // Stamp read runs one entry ahead so that one stamp is checked per cycle.
    assign head_sel    = i_cmd.fetch ? rd_head : (i_cmd.pop ? head_inc : r_head);
    assign flow_base   = AW'(r_flow) * AW'(LOG_DEPTH);
    assign stamp_raddr = flow_base + AW'(head_sel);
    assign stamp_waddr = flow_base + AW'(tail);

    // Age of the oldest stamp against the window.
    assign age = r_now - r_stamp_rd;

    // Limit saturates at the log depth.
    assign limit_sat  = (LW'(i_limit) > LW'(LOG_DEPTH)) ? LW'(LOG_DEPTH) : LW'(i_limit);
    assign accept_req = (LW'(r_count) < limit_sat);
    assign count_new  = accept_req ? r_count + 1'b1 : r_count;

    // Memory write selection: clearing pass or commit of an item.
    assign ring_raddr = i_cmd.take ? in_idx : r_flow;
    assign ring_we    = i_cmd.clear | (i_cmd.commit & ~r_bad);
    assign ring_waddr = i_cmd.clear ? r_clr_idx : r_flow;
    assign ring_wdata = i_cmd.clear ? '0 : {r_head, count_new};
    assign stamp_we   = i_cmd.commit & ~r_bad & accept_req;

    assign out_free = ~r_out_valid | i_m_tready;

    always_comb begin
        o_sts            = '0;
        o_sts.in_bad     = in_bad;
        o_sts.clear_last = (32'(r_clr_idx) == 32'(FLOW_SLOTS - 1));
        o_sts.count_zero = (r_count == '0);
        o_sts.stale      = (CMPW'(age) > CMPW'(i_window));
        o_sts.out_free   = out_free;
    end

    // Ring-state memory with registered read.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        r_ring_rd <= ring_mem[ring_raddr];
    end

    // Stamp memory with registered read.
    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            stamp_mem[stamp_waddr] <= r_now;
        end
        r_stamp_rd <= stamp_mem[stamp_raddr];
    end

    // Item context and working pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_flow <= in_idx;
            r_now  <= STAMP_BITS'(i_now_ticks);
            r_bad  <= in_bad;
        end
        if (i_cmd.fetch) begin
            r_head  <= rd_head;
            r_count <= rd_count;
        end else if (i_cmd.pop) begin
            r_head  <= head_inc;
            r_count <= r_count - 1'b1;
        end
        if (i_cmd.commit) begin
            r_allowed   <= ~r_bad & accept_req;
            r_out_count <= r_bad ? '0 : COUNT_OUT_W'(count_new);
        end
    end

    // Clearing counter and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_allowed      = r_allowed;
    assign o_window_count = r_out_count;

    // Each pop removes exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_count == CW'($past(r_count) - 1'b1))
        else $error("pop did not decrement the entry count");

    // An allowed item always leaves at least its own stamp in the window.
    a_allowed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_allowed |-> r_out_count != '0)
        else $error("allowed result with empty window");

    // An out-of-range flow gives a rejected result with zero count.
    a_bad_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_bad |=> !r_allowed && r_out_count == '0)
        else $error("out-of-range flow not rejected");

endmodule

// File: sim/sliding_window_log_rate_limiter_core_tb.sv
// Self-checking testbench for the sliding-window log rate limiter core.
// Drives request items and register writes, predicts every verdict and checks it.
// Depends on swlrl_pkg and sliding_window_log_rate_limiter_core.
`timescale 1ns / 1ps

module sliding_window_log_rate_limiter_core_tb;
    import swlrl_pkg::*;

    localparam int FLOW_COUNT  = 64;
    localparam int RING_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 55;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};

    // One request item as it is packed into the slave-side tdata.
    typedef struct packed {
        logic [NOW_W-1:0]        now;
        logic [FLOW_FIELD_W-1:0] flow;
    } request_t;

    // One verdict item as it is packed into the master-side tdata.
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   allowed;
    } verdict_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sliding_window_log_rate_limiter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the per-flow timestamp rings and the registers.
    logic [NOW_W-1:0]       stamp_log [FLOW_COUNT][RING_DEPTH];
    logic [3:0]             log_head  [FLOW_COUNT];
    logic [COUNT_OUT_W-1:0] log_count [FLOW_COUNT];
    logic [LIMIT_W-1:0]     cfg_limit;
    logic [WINDOW_W-1:0]    cfg_window;

    request_t pending_requests[$];
    verdict_t expected_verdicts[$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        in_fire = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [FLOW_FIELD_W-1:0] hot_flows [4];
    logic [NOW_W-1:0]        tick_now;

    // Trim stale stamps of the flow, then decide and append as the block does.
    function automatic verdict_t predict_verdict(input logic [FLOW_FIELD_W-1:0] flow,
                                                 input logic [NOW_W-1:0] now);
        logic [3:0]             head;
        logic [3:0]             tail;
        logic [COUNT_OUT_W-1:0] count;
        logic [COUNT_OUT_W-1:0] cap;
        logic [NOW_W-1:0]       age;
        logic                   trimming;
        verdict_t               v;
        head = log_head[flow];
        count = log_count[flow];
        trimming = 1'b1;
        while (trimming && count != 0) begin
            age = now - stamp_log[flow][head];
            if (age <= cfg_window) begin
                trimming = 1'b0;
            end else begin
                head = head + 4'd1;
                count = count - 5'd1;
            end
        end
        // A limit above the ring depth saturates at the depth.
        cap = (cfg_limit > RING_DEPTH) ? 5'(RING_DEPTH) : cfg_limit;
        if (count >= cap) begin
            v.allowed = 1'b0;
        end else begin
            tail = head + count[3:0];
            stamp_log[flow][tail] = now;
            count = count + 5'd1;
            v.allowed = 1'b1;
        end
        log_head[flow] = head;
        log_count[flow] = count;
        v.count = count;
        return v;
    endfunction

    task automatic note_mismatch(input string what, input longint expv, input longint actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, expv, actv);
    endtask

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_log_rate_limiter_core_tb: errors");
            $finish;
        end
    end

    // Check each delivered verdict, then record the prediction for each taken request.
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = verdict_t'(m_axis_tdata[5:0]);
            if (expected_verdicts.size() == 0) begin
                note_mismatch("unexpected item", 0, m_axis_tdata);
            end else begin
                want = expected_verdicts[0];
                expected_verdicts.delete(0);
                if (got.allowed !== want.allowed)
                    note_mismatch("allowed", want.allowed, got.allowed);
                if (got.count !== want.count)
                    note_mismatch("window_count", want.count, got.count);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_verdicts.insert(expected_verdicts.size(),
                                     predict_verdict(s_axis_tdata[5:0],
                                                     s_axis_tdata[37:6]));
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_axis_tdata <= {2'b00, pending_requests[0]};
                pending_requests.delete(0);
                s_axis_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(0, 15);
                    gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                            : $urandom_range(0, 3);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: the stall pattern changes with bits 8 and 7 of the cycle counter.
    always @(negedge i_clk) begin
        case (cycle_count[8:7])
            2'd0: begin
                m_axis_tready <= 1'b1;
            end
            2'd1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= ((cycle_count % 7) < 4);
            end
        endcase
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_mismatch("register readback", want, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers, mirror them in the shadow copy and read them back.
    task automatic apply_settings(input logic [LIMIT_W-1:0] limit,
                                  input logic [WINDOW_W-1:0] window);
        apb_write(ADDR_LIMIT, APB_DATA_W'(limit));
        apb_write(ADDR_WINDOW, window);
        cfg_limit = limit;
        cfg_window = window;
        apb_check(ADDR_LIMIT, APB_DATA_W'(limit));
        apb_check(ADDR_WINDOW, window);
    endtask

    // Hold off until every queued request is taken and every verdict has arrived.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly hot flows with small time steps; some window jumps, time going back and noise.
    task automatic queue_random_requests(input int n, input logic [WINDOW_W-1:0] win);
        int unsigned             r;
        int unsigned             span;
        logic [FLOW_FIELD_W-1:0] flow;
        logic [NOW_W-1:0]        stamp;
        span = (win > 4000) ? 1000 : (win / 4 + 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            flow = hot_flows[$urandom_range(0, 3)];
            if (r < 55)
                tick_now = tick_now + $urandom_range(0, span);
            else if (r >= 70 && r < 80)
                tick_now = tick_now + win + $urandom_range(1, 50);
            else if (r >= 80 && r < 85)
                tick_now = tick_now - $urandom_range(1, span);
            stamp = tick_now;
            if (r >= 85) begin
                flow = FLOW_FIELD_W'($urandom());
                if (r >= 93)
                    stamp = $urandom();
            end
            pending_requests.insert(pending_requests.size(), {stamp, flow});
        end
    endtask

    logic [LIMIT_W-1:0]  phase_limit  [PHASES] = '{5'd10, 5'd1, 5'd4, 5'd16, 5'd31,
                                                   5'd0, 5'd7, 5'd3, 5'd2, 5'd12};
    logic [WINDOW_W-1:0] phase_window [PHASES] = '{32'd60, 32'd50, 32'd200, 32'd1000,
                                                   32'd30, 32'd100, 32'd0, 32'hFFFFFFFF,
                                                   32'd1, 32'd300};

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int f = 0; f < FLOW_COUNT; f++) begin
            log_head[f] = '0;
            log_count[f] = '0;
        end
        cfg_limit = LIMIT_RESET;
        cfg_window = WINDOW_RESET;
        tick_now = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset at their defaults.
        apb_check(ADDR_LIMIT, APB_DATA_W'(LIMIT_RESET));
        apb_check(ADDR_WINDOW, WINDOW_RESET);

        // Timestamp wrap, trimming of two entries, then time going backwards.
        pending_requests.insert(pending_requests.size(), {32'hFFFFFFFF, 6'd63});
        pending_requests.insert(pending_requests.size(), {32'h00000010, 6'd63});
        pending_requests.insert(pending_requests.size(), {32'd100, 6'd63});
        pending_requests.insert(pending_requests.size(), {32'd99, 6'd63});
        wait_idle();

        // Zero limit rejects everything.
        apply_settings(5'd0, 32'd100);
        pending_requests.insert(pending_requests.size(), {32'd5, 6'd0});
        wait_idle();

        // Limit above the ring depth saturates; the widest window keeps every stamp.
        apply_settings(5'd31, 32'hFFFFFFFF);
        for (int t = 0; t <= RING_DEPTH; t++)
            pending_requests.insert(pending_requests.size(), {32'(t), 6'd1});
        wait_idle();

        // Zero window trims a full ring at once but keeps a stamp of age zero.
        apply_settings(5'd16, 32'd0);
        pending_requests.insert(pending_requests.size(), {32'd20, 6'd1});
        pending_requests.insert(pending_requests.size(), {32'd20, 6'd1});
        wait_idle();

        // Random phases; each pauses halfway until all verdicts are in.
        for (int p = 0; p < PHASES; p++) begin
            apply_settings(phase_limit[p], phase_window[p]);
            for (int j = 0; j < 4; j++)
                hot_flows[j] = FLOW_FIELD_W'($urandom_range(0, FLOW_COUNT - 1));
            if (phase_window[p] == 32'hFFFFFFFF)
                tick_now = 32'hFFFFF000;
            queue_random_requests(PHASE_ITEMS / 2, phase_window[p]);
            wait_idle();
            queue_random_requests(PHASE_ITEMS - PHASE_ITEMS / 2, phase_window[p]);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_verdicts.size() != 0)
            note_mismatch("verdicts never delivered", 0, expected_verdicts.size());
        if (mismatch_count == 0)
            $display("sliding_window_log_rate_limiter_core_tb: clean");
        else
            $display("sliding_window_log_rate_limiter_core_tb: errors");
        $finish;
    end

endmodule
